// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/wrs_pkg.sv =====
// Package of the weighted roulette selector: constants, codes and the command record.
// Depends on nothing; the top level, front end, queue, execution unit and checker import it.
`timescale 1ns / 1ps

package wrs_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int DATA_BITS_DEF   = 32;
    localparam int ACC_BITS        = 64;
    localparam int HALF_BITS       = 32;

    localparam int INDEX_BITS   = 8;
    localparam int FIELD_BITS   = 32;
    localparam int STATUS_BITS  = 3;
    localparam int ENTRIES_BITS = 9;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_FIELD_W = STATUS_BITS + FIELD_BITS + INDEX_BITS;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = ENTRIES_BITS;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENTRIES   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_GIVEN = 1'd1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    typedef enum logic [2:0] {
        ST_SELECTED   = 3'd0,
        ST_NO_ENTRIES = 3'd1,
        ST_DRAW_LOW   = 3'd2,
        ST_DRAW_HIGH  = 3'd3,
        ST_WRITE_DONE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_WRITE_SKIP,
        KIND_SELECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [INDEX_BITS-1:0]  index;
        logic [FIELD_BITS-1:0]  weight;
        logic [FIELD_BITS-1:0]  value;
        logic [FIELD_BITS-1:0]  given_draw;
        logic [FIELD_BITS-1:0]  random_word;
    } cmd_t;

    typedef struct packed {
        logic [ENTRIES_BITS-1:0] entries_in_use;
        logic                    use_given_input;
    } cfg_t;

endpackage

// ===== rtl/core/weighted_roulette_select_top.sv =====
// Weighted roulette selector: a table of weight and value pairs and a weighted pick over it.
// A write command stores one entry; a select command returns the first entry whose
// running weight sum exceeds the draw, either a given draw or a scaled random word.
// Input transfers arrive on the s_ stream (tuser 0 writes, 1 selects) and every command
// produces exactly one result transfer on the m_ stream, in command order.
// The user must write registers through cfg_wr_en, cfg_addr and cfg_wr_data only while
// the block is idle; the block itself does not enforce this. A write command passes the
// input stage, the queue and the result register, and the unit takes one per cycle while
// the receiver does not stall. A select makes one table read per cycle over the entries
// in use from the single read port; a random select sums the weights before it scans them.
// One input stage and a two-entry queue let new commands be taken while a selection runs.
// Reset clears the registers, the queue and all handshake state; table contents are not
// cleared and must be written before they are selected from. When the receiver stalls,
// the result stays on m_tdata and the unit waits before starting the next command.
// Depends on wrs_pkg, wrs_front, wrs_queue, wrs_back and wrs_ram.
`timescale 1ns / 1ps

module weighted_roulette_select_top
    import wrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index[7:0], entry_weight[39:8], entry_value[71:40],
    // given_draw[103:72], random_word[135:104]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[2:0], selected_value[34:3], selected_index[42:35], zero pad[47:43]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t                  cfg_reg;
    logic                  fr_valid, fr_ready, q_valid, q_ready;
    cmd_t                  fr_cmd, q_cmd;
    status_t               res_status;
    logic [FIELD_BITS-1:0] res_value;
    logic [INDEX_BITS-1:0] res_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ENTRIES:   cfg_reg.entries_in_use  <= cfg_wr_data;
                CFG_USE_GIVEN: cfg_reg.use_given_input <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    wrs_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    wrs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    wrs_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_BITS   (DATA_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd        (q_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (res_status),
        .out_value  (res_value),
        .out_index  (res_index)
    );

    assign m_tdata = {OUT_PAD_W'(0), res_index, res_value, res_status};

endmodule

// ===== rtl/core/wrs_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module wrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wrs_front.sv =====
// Front end: accepts input transfers, classifies each command and holds it in one stage.
// Depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_front
    import wrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_t                  cmd
);

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic accept;

    assign s_tready = !valid_reg || cmd_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd_next.index       = s_tdata[7:0];
        cmd_next.weight      = s_tdata[39:8];
        cmd_next.value       = s_tdata[71:40];
        cmd_next.given_draw  = s_tdata[103:72];
        cmd_next.random_word = s_tdata[135:104];
        if (s_tuser == CMD_SELECT) begin
            cmd_next.kind = KIND_SELECT;
        end else if (32'(s_tdata[7:0]) < 32'(MAX_ENTRIES)) begin
            cmd_next.kind = KIND_WRITE;
        end else begin
            cmd_next.kind = KIND_WRITE_SKIP;
        end
        if (accept) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== rtl/core/wrs_queue.sv =====
// Two-entry command queue between the front end and the execution unit.
// Depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_queue
    import wrs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/core/wrs_back.sv =====
// Execution unit: writes table entries, sums and scans the table for selections,
// scales the random draw and holds the result register. Depends on wrs_pkg and wrs_ram.
`timescale 1ns / 1ps

module wrs_back
    import wrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output status_t               out_status,
    output logic [FIELD_BITS-1:0] out_value,
    output logic [INDEX_BITS-1:0] out_index
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MUL_LO,
        S_MUL_HI,
        S_DRAW,
        S_CHECK,
        S_SCAN
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cur_reg, cur_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pend_reg, pend_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [ACC_BITS-1:0]    draw_reg, draw_next;
    logic [ACC_BITS-1:0]    prod_reg, prod_next;
    logic [HALF_BITS-1:0]   frac_reg, frac_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [FIELD_BITS-1:0]  out_value_reg, out_value_next;
    logic [INDEX_BITS-1:0]  out_index_reg, out_index_next;

    logic [CNT_W-1:0]       n_entries;
    logic                   out_free;
    logic                   ram_we, ram_re;
    logic [2*DATA_BITS-1:0] ram_wdata, ram_rdata;
    logic signed [DATA_BITS-1:0] wr_weight, wr_value, given_d, rd_weight, rd_value;
    logic [ACC_BITS-1:0]    weight_ext, acc_sum;
    logic [HALF_BITS-1:0]   mul_b;
    logic [ACC_BITS-1:0]    mul_p;
    logic                   last_read, hit;

    assign n_entries = (32'(cfg.entries_in_use) > 32'(MAX_ENTRIES)) ?
                       CNT_W'(MAX_ENTRIES) : CNT_W'(cfg.entries_in_use);
    assign out_free  = !out_valid_reg || m_tready;

    assign wr_weight = DATA_BITS'($signed(cmd.weight));
    assign wr_value  = DATA_BITS'($signed(cmd.value));
    assign given_d   = DATA_BITS'($signed(cmd.given_draw));
    assign ram_wdata = {wr_value, wr_weight};
    assign rd_weight = ram_rdata[DATA_BITS-1:0];
    assign rd_value  = ram_rdata[2*DATA_BITS-1:DATA_BITS];
    assign weight_ext = ACC_BITS'(rd_weight);
    assign acc_sum    = acc_reg + weight_ext;
    assign last_read  = rd_idx_reg == (n_entries - CNT_W'(1));
    assign hit        = $signed(draw_reg) < $signed(acc_sum);

    assign mul_b = (state_reg == S_MUL_LO) ? acc_reg[HALF_BITS-1:0]
                                           : acc_reg[ACC_BITS-1:HALF_BITS];
    assign mul_p = cur_reg.random_word * mul_b;

    assign ram_re = ((state_reg == S_SUM) || (state_reg == S_SCAN)) && (issue_reg < n_entries);

    wrs_ram #(
        .WIDTH (2 * DATA_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ADDR_W'(cmd.index)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        issue_next      = issue_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        acc_next        = acc_reg;
        draw_next       = draw_reg;
        prod_next       = prod_reg;
        frac_next       = frac_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        cmd_ready       = 1'b0;
        ram_we          = 1'b0;

        if (ram_re) begin
            issue_next  = issue_reg + CNT_W'(1);
            rd_idx_next = issue_reg;
            pend_next   = 1'b1;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready  = 1'b1;
                    cur_next   = cmd;
                    acc_next   = '0;
                    issue_next = '0;
                    out_value_next = '0;
                    out_index_next = '0;
                    unique case (cmd.kind)
                        KIND_WRITE: begin
                            ram_we          = 1'b1;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_WRITE_DONE;
                        end
                        KIND_WRITE_SKIP: begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_WRITE_DONE;
                        end
                        KIND_SELECT: begin
                            if (n_entries == '0) begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_NO_ENTRIES;
                            end else if (cfg.use_given_input) begin
                                draw_next  = ACC_BITS'(given_d);
                                state_next = S_CHECK;
                            end else begin
                                state_next = S_SUM;
                            end
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_WRITE_DONE;
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (pend_reg) begin
                    acc_next = acc_sum;
                    if (last_read) begin
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO: begin
                if ($signed(acc_reg) > 0) begin
                    prod_next  = mul_p;
                    state_next = S_MUL_HI;
                end else begin
                    draw_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_MUL_HI: begin
                frac_next  = prod_reg[ACC_BITS-1:HALF_BITS];
                prod_next  = mul_p;
                state_next = S_DRAW;
            end
            S_DRAW: begin
                draw_next  = prod_reg + ACC_BITS'(frac_reg);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                acc_next   = '0;
                issue_next = '0;
                if (draw_reg[ACC_BITS-1]) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DRAW_LOW;
                    state_next      = S_IDLE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (pend_reg) begin
                    acc_next = acc_sum;
                    if (hit) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_SELECTED;
                        out_value_next  = FIELD_BITS'(rd_value);
                        out_index_next  = INDEX_BITS'(rd_idx_reg);
                        state_next      = S_IDLE;
                    end else if (last_read) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_DRAW_HIGH;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            issue_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            issue_reg     <= issue_next;
        end
        cur_reg        <= cur_next;
        rd_idx_reg     <= rd_idx_next;
        acc_reg        <= acc_next;
        draw_reg       <= draw_next;
        prod_reg       <= prod_next;
        frac_reg       <= frac_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_index  = out_index_reg;

endmodule

// ===== rtl/core/wrs_checker.sv =====
// Port-level checker for the weighted roulette selector, bound to the top level.
// Depends on wrs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wrs_checker
    import wrs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    `ASSERT_CLK_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `ASSERT_CLK(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result transfer changed")

    `ASSERT_CLK(a_status_known, aclk, aresetn, m_tvalid |-> (m_tdata[2:0] == ST_SELECTED) || (m_tdata[2:0] == ST_NO_ENTRIES) || (m_tdata[2:0] == ST_DRAW_LOW) || (m_tdata[2:0] == ST_DRAW_HIGH) || (m_tdata[2:0] == ST_WRITE_DONE), "unknown status code")

    `ASSERT_CLK(a_clear_fields, aclk, aresetn, m_tvalid && (m_tdata[2:0] != ST_SELECTED) |-> m_tdata[OUT_TDATA_W-1:STATUS_BITS] == '0, "value or index set on a non-selection result")

endmodule

bind weighted_roulette_select_top wrs_checker u_wrs_checker (.*);
